### src/gear_stepped_motor_drive_controller_assert.svh
// Assertion macros shared by the controller's modules.
// Each macro expects a signal named clk, and GSMD_ASSERT also rst_n, in the module that uses it.
`ifndef GEAR_STEPPED_MOTOR_DRIVE_CONTROLLER_ASSERT_SVH
`define GEAR_STEPPED_MOTOR_DRIVE_CONTROLLER_ASSERT_SVH

// Property checked at every rising edge outside reset.
`define GSMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define GSMD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/gsmd_pkg.sv
`timescale 1ns / 1ps

package gsmd_pkg;

  // Number of gears in the table.
  localparam int unsigned GEARS = 5;

  // Field widths.
  localparam int unsigned GEAR_W   = 3;
  localparam int unsigned LED_W    = 5;
  localparam int unsigned DRIVE_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 10;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_PERIOD    = 3'd0,
    CFG_DEBOUNCE_SAMPLES = 3'd1,
    CFG_BLINK_COUNT      = 3'd2,
    CFG_PAUSE_TICKS      = 3'd3,
    CFG_DIM_ON_TICKS     = 3'd4,
    CFG_DIM_OFF_TICKS    = 3'd5,
    CFG_DIM_REPEATS      = 3'd6
  } cfg_idx_t;

  // Motor drive codes.
  typedef enum logic [DRIVE_W-1:0] {
    DRV_IDLE    = 2'd0,
    DRV_PHASE_A = 2'd1,
    DRV_PHASE_B = 2'd2
  } drive_t;

  // Configuration register set.
  typedef struct packed {
    logic [6:0] sample_period;
    logic [3:0] debounce_samples;
    logic [2:0] blink_count;
    logic [9:0] pause_ticks;
    logic [4:0] dim_on_ticks;
    logic [6:0] dim_off_ticks;
    logic [5:0] dim_repeats;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sample_period:    7'd100,
    debounce_samples: 4'd10,
    blink_count:      3'd6,
    pause_ticks:      10'd1000,
    dim_on_ticks:     5'd20,
    dim_off_ticks:    7'd80,
    dim_repeats:      6'd10
  };

  // Per-tick commands from the control unit to the motor and LED units.
  typedef struct packed {
    logic              step;         // awake tick: run the counters
    logic              clear;        // force drive and LEDs off
    logic              load_gear_en; // reload pulse and gap lengths
    logic [GEAR_W-1:0] gear;         // gear to load
    logic              blink_load;   // overwrite the blink counter
    logic [2:0]        blink_val;
  } cmd_t;

  // True for gears that have a table entry.
  function automatic logic gear_in_table(input logic [GEAR_W-1:0] g);
    return (g >= 3'd1) && (g <= 3'd5);
  endfunction

  // Pulse length of a gear.
  function automatic logic [4:0] gear_pulse(input logic [GEAR_W-1:0] g);
    logic [4:0] p;
    case (g)
      3'd1: p = 5'd16;
      3'd2: p = 5'd16;
      3'd3: p = 5'd16;
      3'd4: p = 5'd8;
      3'd5: p = 5'd8;
      default: p = 5'd0;
    endcase
    return p;
  endfunction

  // Gap length of a gear.
  function automatic logic [3:0] gear_gap(input logic [GEAR_W-1:0] g);
    logic [3:0] q;
    case (g)
      3'd1: q = 4'd2;
      3'd2: q = 4'd4;
      3'd3: q = 4'd6;
      3'd4: q = 4'd9;
      3'd5: q = 4'd12;
      default: q = 4'd0;
    endcase
    return q;
  endfunction

  // One LED for the current gear; none for a gear outside the LED row.
  function automatic logic [LED_W-1:0] gear_led(input logic [GEAR_W-1:0] g);
    logic [LED_W-1:0] l;
    for (int i = 0; i < LED_W; i++) begin
      l[i] = ({1'b0, g} == 4'(i + 1));
    end
    return l;
  endfunction

endpackage

### src/gsmd_in_if.sv
`timescale 1ns / 1ps

// Tick channel: one button level per transfer.
interface gsmd_in_if;
  logic valid;
  logic ready;
  logic key_down;

  modport source (output valid, output key_down, input ready);
  modport sink (input valid, input key_down, output ready);
endinterface

### src/gsmd_out_if.sv
`timescale 1ns / 1ps

// Result channel: drive code, LED pattern and gear per transfer.
interface gsmd_out_if;
  logic                          valid;
  logic                          ready;
  logic [gsmd_pkg::DRIVE_W-1:0]  motor_drive;
  logic [gsmd_pkg::LED_W-1:0]    led_lit;
  logic [gsmd_pkg::GEAR_W-1:0]   gear;

  modport source (output valid, output motor_drive, output led_lit, output gear, input ready);
  modport sink (input valid, input motor_drive, input led_lit, input gear, output ready);
endinterface

### src/gear_stepped_motor_drive_controller.sv
`timescale 1ns / 1ps

// Gear-stepped motor drive controller. Each transfer on in_ch is one timer tick with the
// button level; each tick yields exactly one transfer on out_ch carrying the motor drive code
// (0 idle, 1 phase A, 2 phase B), the LED pattern and the gear (0 while asleep). The block
// takes one tick per clock cycle while out_ch is ready: a tick is held in an input register,
// worked out combinationally by the control, motor and LED units, and lands in an output
// register, which lets the next tick in while a result still waits. Configuration is written
// through cfg_wr_en, cfg_idx and cfg_wdata (low bits used) and must only change while no tick
// is in flight; index 7 is ignored. After reset the block is awake in gear 1 with the blink
// bursts running.

`include "gear_stepped_motor_drive_controller_assert.svh"

module gear_stepped_motor_drive_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  gsmd_in_if.sink                           in_ch,
  gsmd_out_if.source                        out_ch,
  input  logic                              cfg_wr_en,
  input  logic [gsmd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [gsmd_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  gsmd_pkg::cfg_t              cfg_r;
  gsmd_pkg::cmd_t              cmd;
  gsmd_pkg::drive_t            drive_nxt;
  logic [gsmd_pkg::LED_W-1:0]  led_nxt;
  logic [gsmd_pkg::GEAR_W-1:0] gear_cur;
  logic [gsmd_pkg::GEAR_W-1:0] gear_out;
  logic [2:0]                  blinks_tick;

  logic                        in_vld_r;
  logic                        in_key_r;
  logic                        out_vld_r;
  logic [gsmd_pkg::DRIVE_W-1:0] out_drive_r;
  logic [gsmd_pkg::LED_W-1:0]  out_led_r;
  logic [gsmd_pkg::GEAR_W-1:0] out_gear_r;
  logic                        fire;

  // A held tick advances when the output register is free or being emptied.
  assign fire         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= gsmd_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      case (gsmd_pkg::cfg_idx_t'(cfg_idx))
        gsmd_pkg::CFG_SAMPLE_PERIOD:    cfg_r.sample_period    <= cfg_wdata[6:0];
        gsmd_pkg::CFG_DEBOUNCE_SAMPLES: cfg_r.debounce_samples <= cfg_wdata[3:0];
        gsmd_pkg::CFG_BLINK_COUNT:      cfg_r.blink_count      <= cfg_wdata[2:0];
        gsmd_pkg::CFG_PAUSE_TICKS:      cfg_r.pause_ticks      <= cfg_wdata[9:0];
        gsmd_pkg::CFG_DIM_ON_TICKS:     cfg_r.dim_on_ticks     <= cfg_wdata[4:0];
        gsmd_pkg::CFG_DIM_OFF_TICKS:    cfg_r.dim_off_ticks    <= cfg_wdata[6:0];
        gsmd_pkg::CFG_DIM_REPEATS:      cfg_r.dim_repeats      <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_key_r <= in_ch.key_down;
    end
  end

  gsmd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (fire),
    .key         (in_key_r),
    .cfg         (cfg_r),
    .blinks_tick (blinks_tick),
    .cmd         (cmd),
    .gear_cur    (gear_cur),
    .gear_out    (gear_out)
  );

  gsmd_motor u_motor (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .drive_nxt (drive_nxt)
  );

  gsmd_led u_led (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg_r),
    .gear_cur    (gear_cur),
    .blinks_tick (blinks_tick),
    .led_nxt     (led_nxt)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_drive_r <= drive_nxt;
      out_led_r   <= led_nxt;
      out_gear_r  <= gear_out;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.motor_drive = out_drive_r;
  assign out_ch.led_lit     = out_led_r;
  assign out_ch.gear        = out_gear_r;

  // Every advanced tick leaves a result behind.
  `GSMD_ASSERT(a_fire_fills_out, fire |=> out_vld_r, "advanced tick left no result")
  // A tick that cannot advance stays in the input register.
  `GSMD_ASSERT(a_in_hold, in_vld_r && !fire |=> in_vld_r && $stable(in_key_r), "held tick lost")
  // While asleep the motor and the LEDs are off.
  `GSMD_ASSERT(a_sleep_dark, out_vld_r && (out_gear_r == '0) |-> (out_drive_r == gsmd_pkg::DRV_IDLE) && (out_led_r == '0), "output active while asleep")

endmodule

### src/gsmd_motor.sv
`timescale 1ns / 1ps

// Motor phase sequencer: phase-A pulse, gap, phase-B pulse, gap, and so on.
module gsmd_motor (
  input  logic              clk,
  input  logic              rst_n,
  input  gsmd_pkg::cmd_t    cmd,
  output gsmd_pkg::drive_t  drive_nxt
);

  logic [4:0]       phase_a_r, phase_a_nxt;
  logic [4:0]       phase_b_r, phase_b_nxt;
  logic [7:0]       gap_cnt_r, gap_cnt_nxt;
  logic             next_is_a_r, next_is_a_nxt;
  logic [4:0]       pulse_len_r, pulse_len_nxt;
  logic [3:0]       gap_len_r, gap_len_nxt;
  gsmd_pkg::drive_t drive_r;
  logic [7:0]       gap_inc;

  // Next state of the phase counters for one tick.
  always_comb begin
    phase_a_nxt   = phase_a_r;
    phase_b_nxt   = phase_b_r;
    gap_cnt_nxt   = gap_cnt_r;
    next_is_a_nxt = next_is_a_r;
    pulse_len_nxt = pulse_len_r;
    gap_len_nxt   = gap_len_r;
    drive_nxt     = drive_r;
    gap_inc       = gap_cnt_r + 8'd1;

    if (cmd.step) begin
      if (phase_a_r != 5'd0) begin
        phase_a_nxt = phase_a_r - 5'd1;
        phase_b_nxt = 5'd0;
        gap_cnt_nxt = 8'd0;
        drive_nxt   = gsmd_pkg::DRV_PHASE_A;
      end else if (phase_b_r != 5'd0) begin
        phase_b_nxt = phase_b_r - 5'd1;
        phase_a_nxt = 5'd0;
        gap_cnt_nxt = 8'd0;
        drive_nxt   = gsmd_pkg::DRV_PHASE_B;
      end else begin
        gap_cnt_nxt = gap_inc;
        drive_nxt   = gsmd_pkg::DRV_IDLE;
        // The gap is over: arm the opposite phase.
        if (gap_inc == {4'd0, gap_len_r}) begin
          if (next_is_a_r) begin
            phase_a_nxt   = pulse_len_r;
            next_is_a_nxt = 1'b0;
          end else begin
            phase_b_nxt   = pulse_len_r;
            next_is_a_nxt = 1'b1;
          end
        end
      end
    end

    if (cmd.clear) begin
      drive_nxt = gsmd_pkg::DRV_IDLE;
    end

    // A new gear's pulse length takes effect from the next pulse onwards, its gap length in the gap under way.
    if (cmd.load_gear_en && gsmd_pkg::gear_in_table(cmd.gear)) begin
      pulse_len_nxt = gsmd_pkg::gear_pulse(cmd.gear);
      gap_len_nxt   = gsmd_pkg::gear_gap(cmd.gear);
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_a_r   <= 5'd16;
      phase_b_r   <= 5'd16;
      gap_cnt_r   <= 8'd0;
      next_is_a_r <= 1'b0;
      pulse_len_r <= 5'd16;
      gap_len_r   <= 4'd2;
      drive_r     <= gsmd_pkg::DRV_IDLE;
    end else begin
      phase_a_r   <= phase_a_nxt;
      phase_b_r   <= phase_b_nxt;
      gap_cnt_r   <= gap_cnt_nxt;
      next_is_a_r <= next_is_a_nxt;
      pulse_len_r <= pulse_len_nxt;
      gap_len_r   <= gap_len_nxt;
      drive_r     <= drive_nxt;
    end
  end

endmodule

### src/gsmd_led.sv
`timescale 1ns / 1ps

// Gear indicator with dim blink bursts.
module gsmd_led (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gsmd_pkg::cmd_t                cmd,
  input  gsmd_pkg::cfg_t                cfg,
  input  logic [gsmd_pkg::GEAR_W-1:0]   gear_cur,
  output logic [2:0]                    blinks_tick,
  output logic [gsmd_pkg::LED_W-1:0]    led_nxt
);

  logic [2:0]                 blinks_r, blinks_nxt;
  logic [9:0]                 pause_r, pause_nxt;
  logic [4:0]                 dim_on_r, dim_on_nxt;
  logic [6:0]                 dim_off_r, dim_off_nxt;
  logic [5:0]                 rep_r, rep_nxt;
  logic [gsmd_pkg::LED_W-1:0] led_r;
  logic [gsmd_pkg::LED_W-1:0] ind;
  logic [6:0]                 dim_off_dec;
  logic [5:0]                 rep_dec;

  assign ind         = gsmd_pkg::gear_led(gear_cur);
  assign dim_off_dec = dim_off_r - 7'd1;
  assign rep_dec     = rep_r - 6'd1;

  // Pause, then dim periods of all-lit and indicator-only ticks.
  always_comb begin
    blinks_tick = blinks_r;
    pause_nxt   = pause_r;
    dim_on_nxt  = dim_on_r;
    dim_off_nxt = dim_off_r;
    rep_nxt     = rep_r;
    led_nxt     = led_r;

    if (cmd.step) begin
      if (blinks_r == 3'd0) begin
        led_nxt = ind;
      end else if (pause_r != 10'd0) begin
        led_nxt   = ind;
        pause_nxt = pause_r - 10'd1;
      end else if (dim_on_r != 5'd0) begin
        dim_on_nxt  = dim_on_r - 5'd1;
        led_nxt     = {gsmd_pkg::LED_W{1'b1}};
        dim_off_nxt = cfg.dim_off_ticks;
      end else begin
        dim_off_nxt = dim_off_dec;
        led_nxt     = ind;
        // End of one dim period; end of the burst after the last repeat.
        if (dim_off_dec == 7'd0) begin
          dim_on_nxt = cfg.dim_on_ticks;
          rep_nxt    = rep_dec;
          if (rep_dec == 6'd0) begin
            rep_nxt     = cfg.dim_repeats;
            blinks_tick = blinks_r - 3'd1;
            pause_nxt   = cfg.pause_ticks;
          end
        end
      end
    end

    if (cmd.clear) begin
      led_nxt = '0;
    end
  end

  assign blinks_nxt = cmd.blink_load ? cmd.blink_val : blinks_tick;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blinks_r  <= 3'd6;
      pause_r   <= 10'd1000;
      dim_on_r  <= 5'd20;
      dim_off_r <= 7'd80;
      rep_r     <= 6'd60;
      led_r     <= '0;
    end else begin
      blinks_r  <= blinks_nxt;
      pause_r   <= pause_nxt;
      dim_on_r  <= dim_on_nxt;
      dim_off_r <= dim_off_nxt;
      rep_r     <= rep_nxt;
      led_r     <= led_nxt;
    end
  end

endmodule

### src/gsmd_ctrl.sv
`timescale 1ns / 1ps

`include "gear_stepped_motor_drive_controller_assert.svh"

// Sleep, button debounce and gear stepping.
module gsmd_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          key,
  input  gsmd_pkg::cfg_t                cfg,
  input  logic [2:0]                    blinks_tick,
  output gsmd_pkg::cmd_t                cmd,
  output logic [gsmd_pkg::GEAR_W-1:0]   gear_cur,
  output logic [gsmd_pkg::GEAR_W-1:0]   gear_out
);

  logic [gsmd_pkg::GEAR_W-1:0] cur_gear_r, cur_gear_nxt;
  logic [gsmd_pkg::GEAR_W-1:0] saved_gear_r, saved_gear_nxt;
  logic                        asleep_r, asleep_nxt;
  logic [6:0]                  sample_div_r, sample_div_nxt;
  logic [3:0]                  held_r, held_nxt;
  logic [6:0]                  div_inc;
  logic                        sample_hit;
  logic [4:0]                  held_inc;
  logic [3:0]                  gear_inc;
  logic                        press;

  assign div_inc    = sample_div_r + 7'd1;
  assign sample_hit = (div_inc == cfg.sample_period);
  assign held_inc   = {1'b0, held_r} + 5'd1;
  assign gear_inc   = {1'b0, cur_gear_r} + 4'd1;
  assign press      = (held_r >= cfg.debounce_samples);

  // Next state and commands for one accepted tick.
  always_comb begin
    cur_gear_nxt   = cur_gear_r;
    saved_gear_nxt = saved_gear_r;
    asleep_nxt     = asleep_r;
    sample_div_nxt = sample_div_r;
    held_nxt       = held_r;
    cmd            = '0;

    if (adv) begin
      if (asleep_r) begin
        // A pressed tick wakes the block in the saved gear.
        if (key) begin
          asleep_nxt       = 1'b0;
          cur_gear_nxt     = saved_gear_r;
          cmd.blink_load   = 1'b1;
          cmd.blink_val    = cfg.blink_count;
          cmd.load_gear_en = 1'b1;
          cmd.gear         = saved_gear_r;
          cmd.clear        = 1'b1;
        end
      end else begin
        cmd.step       = 1'b1;
        sample_div_nxt = div_inc;
        if (sample_hit) begin
          sample_div_nxt = 7'd0;
          if (key) begin
            held_nxt = (held_inc >= {1'b0, cfg.debounce_samples}) ?
                       cfg.debounce_samples : held_inc[3:0];
          end else begin
            held_nxt = 4'd0;
            // Release after a long hold.
            if (press) begin
              cmd.clear      = 1'b1;
              saved_gear_nxt = cur_gear_r;
              if (blinks_tick != 3'd0) begin
                if (gear_inc > 4'(gsmd_pkg::GEARS)) begin
                  asleep_nxt     = 1'b1;
                  cmd.blink_load = 1'b1;
                  cmd.blink_val  = 3'd0;
                  saved_gear_nxt = 3'd1;
                end else begin
                  cur_gear_nxt     = gear_inc[2:0];
                  cmd.blink_load   = 1'b1;
                  cmd.blink_val    = cfg.blink_count;
                  cmd.load_gear_en = 1'b1;
                  cmd.gear         = gear_inc[2:0];
                end
              end else begin
                asleep_nxt = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  assign gear_cur = cur_gear_r;
  assign gear_out = asleep_nxt ? '0 : cur_gear_nxt;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_gear_r   <= 3'd1;
      saved_gear_r <= 3'd1;
      asleep_r     <= 1'b0;
      sample_div_r <= 7'd0;
      held_r       <= 4'd0;
    end else begin
      cur_gear_r   <= cur_gear_nxt;
      saved_gear_r <= saved_gear_nxt;
      asleep_r     <= asleep_nxt;
      sample_div_r <= sample_div_nxt;
      held_r       <= held_nxt;
    end
  end

  // The current and saved gears always have a table entry.
  `GSMD_ASSERT(a_gear_range, (cur_gear_r >= 3'd1) && (cur_gear_r <= 3'(gsmd_pkg::GEARS)) && (saved_gear_r >= 3'd1) && (saved_gear_r <= 3'(gsmd_pkg::GEARS)), "gear out of range")
  // Without a transfer nothing in the control state moves.
  `GSMD_ASSERT(a_hold_idle, !adv |=> $stable(cur_gear_r) && $stable(asleep_r) && $stable(sample_div_r) && $stable(held_r), "control state moved without a transfer")
  // Only a sample tick can send the block to sleep or change the hold count.
  `GSMD_ASSERT(a_sleep_on_sample, adv && !asleep_r && !sample_hit |=> !asleep_r && $stable(held_r), "sleep or debounce change off a sample tick")
  // An unpressed tick while asleep changes nothing.
  `GSMD_ASSERT(a_stay_asleep, adv && asleep_r && !key |=> asleep_r && $stable(cur_gear_r), "woke without a press")

endmodule
